// ===== design/skf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// skf_pkg
// Shared types, constants and the microprogram of the scalar Kalman filter.
// ----------------------------------------------------------------------------
package skf_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned MEAS_W    = 16;
  localparam int unsigned GAIN_W    = 17;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CNT_W     = 5;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_ERROR     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_ESTIMATE  = 8'd3;

  localparam logic [DATA_W-1:0] RST_PROCESS_NOISE     = 32'd655;
  localparam logic [DATA_W-1:0] RST_MEASUREMENT_NOISE = 32'd65536;
  localparam logic [DATA_W-1:0] RST_INITIAL_ERROR     = 32'd65536;
  localparam logic [DATA_W-1:0] RST_INITIAL_ESTIMATE  = 32'd0;
  localparam logic [DATA_W-1:0] RST_COVARIANCE        = 32'd65536;
  localparam logic [DATA_W-1:0] RST_ESTIMATE          = 32'd0;

  localparam logic [GAIN_W-1:0] GAIN_ONE  = 17'h10000;
  // iterations of the divider and multiplier loops, minus one
  localparam logic [CNT_W-1:0]  LOOP_LAST = 5'd16;

  typedef logic [3:0] pc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_WAIT,
    OP_PRED,
    OP_DIVINIT,
    OP_DIVSTEP,
    OP_MULX,
    OP_MULSTEP,
    OP_XROUND,
    OP_XUPD,
    OP_PUPD,
    OP_RELOAD,
    OP_OUT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ITEM,
    C_RELOAD,
    C_S_ZERO,
    C_CNT_NZ,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    logic  cnt_load;
    pc_t   target;
  } uword_t;

  typedef struct packed {
    logic no_item;
    logic reload;
    logic s_zero;
    logic out_busy;
  } dp_stat_t;

  typedef struct packed {
    logic [DATA_W-1:0] process_noise;
    logic [DATA_W-1:0] measurement_noise;
    logic [DATA_W-1:0] initial_error;
    logic [DATA_W-1:0] initial_estimate;
  } cfg_t;

  // program addresses
  localparam pc_t ST_WAIT     = 4'd0;
  localparam pc_t ST_CHECK    = 4'd1;
  localparam pc_t ST_PRED     = 4'd2;
  localparam pc_t ST_DIVINIT  = 4'd3;
  localparam pc_t ST_DIVSTEP  = 4'd4;
  localparam pc_t ST_MULX     = 4'd5;
  localparam pc_t ST_MULX_RUN = 4'd6;
  localparam pc_t ST_XROUND   = 4'd7;
  localparam pc_t ST_XUPD     = 4'd8;
  localparam pc_t ST_MULP_RUN = 4'd9;
  localparam pc_t ST_PUPD     = 4'd10;
  localparam pc_t ST_RELOAD   = 4'd11;
  localparam pc_t ST_OUT      = 4'd12;
  localparam pc_t ST_DONE     = 4'd13;

  function automatic uword_t rom_word(input pc_t pc);
    uword_t w;
    case (pc)
      ST_WAIT:     w = '{op: OP_WAIT,    cond: C_NO_ITEM,  cnt_load: 1'b0, target: ST_WAIT};
      ST_CHECK:    w = '{op: OP_NOP,     cond: C_RELOAD,   cnt_load: 1'b0, target: ST_RELOAD};
      ST_PRED:     w = '{op: OP_PRED,    cond: C_NEVER,    cnt_load: 1'b0, target: ST_WAIT};
      ST_DIVINIT:  w = '{op: OP_DIVINIT, cond: C_S_ZERO,   cnt_load: 1'b1, target: ST_MULX};
      ST_DIVSTEP:  w = '{op: OP_DIVSTEP, cond: C_CNT_NZ,   cnt_load: 1'b0, target: ST_DIVSTEP};
      ST_MULX:     w = '{op: OP_MULX,    cond: C_NEVER,    cnt_load: 1'b1, target: ST_WAIT};
      ST_MULX_RUN: w = '{op: OP_MULSTEP, cond: C_CNT_NZ,   cnt_load: 1'b0, target: ST_MULX_RUN};
      ST_XROUND:   w = '{op: OP_XROUND,  cond: C_NEVER,    cnt_load: 1'b0, target: ST_WAIT};
      ST_XUPD:     w = '{op: OP_XUPD,    cond: C_NEVER,    cnt_load: 1'b1, target: ST_WAIT};
      ST_MULP_RUN: w = '{op: OP_MULSTEP, cond: C_CNT_NZ,   cnt_load: 1'b0, target: ST_MULP_RUN};
      ST_PUPD:     w = '{op: OP_PUPD,    cond: C_ALWAYS,   cnt_load: 1'b0, target: ST_OUT};
      ST_RELOAD:   w = '{op: OP_RELOAD,  cond: C_NEVER,    cnt_load: 1'b0, target: ST_WAIT};
      ST_OUT:      w = '{op: OP_OUT,     cond: C_OUT_BUSY, cnt_load: 1'b0, target: ST_OUT};
      ST_DONE:     w = '{op: OP_NOP,     cond: C_ALWAYS,   cnt_load: 1'b0, target: ST_WAIT};
      default:     w = '{op: OP_NOP,     cond: C_ALWAYS,   cnt_load: 1'b0, target: ST_WAIT};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== design/skf_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// skf_in_if
// Input item channel: filter action and raw sensor sample.
// ----------------------------------------------------------------------------
interface skf_in_if;
  logic                             valid;
  logic                             ready;
  logic                             action;
  logic signed [skf_pkg::MEAS_W-1:0] measurement;

  modport source (output valid, action, measurement, input ready);
  modport sink   (input valid, action, measurement, output ready);
endinterface
`default_nettype wire

// ===== design/skf_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// skf_out_if
// Result item channel: updated estimate and the gain that produced it.
// ----------------------------------------------------------------------------
interface skf_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [skf_pkg::DATA_W-1:0] estimate;
  logic        [skf_pkg::GAIN_W-1:0] gain;

  modport source (output valid, estimate, gain, input ready);
  modport sink   (input valid, estimate, gain, output ready);
endinterface
`default_nettype wire

// ===== design/skf_cfg_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// skf_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface skf_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [skf_pkg::CFG_IDX_W-1:0]       index;
  logic [skf_pkg::DATA_W-1:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/skf_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// skf_cfg_regs
// Configuration register file: noise terms and reload values.
// ----------------------------------------------------------------------------
module skf_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst_n,
  skf_cfg_if.sink            cfg_ch,
  output skf_pkg::cfg_t      cfg
);

  skf_pkg::cfg_t cfg_r;
  skf_pkg::cfg_t cfg_nxt;

  assign cfg_ch.ready = rst_n;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        skf_pkg::REG_PROCESS_NOISE:     cfg_nxt.process_noise     = cfg_ch.data;
        skf_pkg::REG_MEASUREMENT_NOISE: cfg_nxt.measurement_noise = cfg_ch.data;
        skf_pkg::REG_INITIAL_ERROR:     cfg_nxt.initial_error     = cfg_ch.data;
        skf_pkg::REG_INITIAL_ESTIMATE:  cfg_nxt.initial_estimate  = cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.process_noise     <= skf_pkg::RST_PROCESS_NOISE;
      cfg_r.measurement_noise <= skf_pkg::RST_MEASUREMENT_NOISE;
      cfg_r.initial_error     <= skf_pkg::RST_INITIAL_ERROR;
      cfg_r.initial_estimate  <= skf_pkg::RST_INITIAL_ESTIMATE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/skf_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// skf_seq
// Microcode sequencer: step counter, program ROM, loop counter, jumps.
// ----------------------------------------------------------------------------
module skf_seq (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire skf_pkg::dp_stat_t stat,
  output skf_pkg::op_t          op
);

  skf_pkg::pc_t                 pc_r, pc_nxt;
  logic [skf_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  skf_pkg::uword_t              uw;
  logic                         taken;

  assign uw = skf_pkg::rom_word(pc_r);
  assign op = uw.op;

  always_comb begin
    case (uw.cond)
      skf_pkg::C_NEVER:    taken = 1'b0;
      skf_pkg::C_ALWAYS:   taken = 1'b1;
      skf_pkg::C_NO_ITEM:  taken = stat.no_item;
      skf_pkg::C_RELOAD:   taken = stat.reload;
      skf_pkg::C_S_ZERO:   taken = stat.s_zero;
      skf_pkg::C_CNT_NZ:   taken = (cnt_r != '0);
      skf_pkg::C_OUT_BUSY: taken = stat.out_busy;
      default:             taken = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt = taken ? uw.target : pc_r + 4'd1;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (uw.cnt_load) begin
      cnt_nxt = skf_pkg::LOOP_LAST;
    end else if (uw.cond == skf_pkg::C_CNT_NZ && cnt_r != '0) begin
      cnt_nxt = cnt_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= skf_pkg::ST_WAIT;
      cnt_r <= '0;
    end else begin
      pc_r  <= pc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/skf_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// skf_dp
// Filter datapath: state, restoring divider, shift-add multiplier, result reg.
// ----------------------------------------------------------------------------
module skf_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire skf_pkg::op_t      op,
  input  wire skf_pkg::cfg_t     cfg,
  skf_in_if.sink                 in_ch,
  skf_out_if.source              out_ch,
  output skf_pkg::dp_stat_t      stat
);

  // filter state
  logic        [31:0] p_r, p_nxt;
  logic signed [31:0] x_r, x_nxt;
  logic        [16:0] k_r, k_nxt;
  // divider
  logic        [32:0] s_r, s_nxt;
  logic        [33:0] rem_r, rem_nxt;
  // multiplier
  logic signed [51:0] acc_r, acc_nxt;
  logic signed [33:0] mcand_r, mcand_nxt;
  logic        [16:0] mplier_r, mplier_nxt;
  // latched item
  logic               act_r, act_nxt;
  logic signed [15:0] meas_r, meas_nxt;
  // result register
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_est_r, out_est_nxt;
  logic        [16:0] out_gain_r, out_gain_nxt;

  logic        [32:0] pred_sum;
  logic        [33:0] div_diff;
  logic               div_ge;
  logic        [33:0] div_rem;
  logic signed [51:0] mul_add;
  logic signed [51:0] rnd_sum;
  logic signed [36:0] x_sum;
  logic               accept;
  logic               out_free;

  assign in_ch.ready = rst_n && (op == skf_pkg::OP_WAIT);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign stat.no_item  = !in_ch.valid;
  assign stat.reload   = act_r;
  assign stat.s_zero   = (p_r == '0) && (cfg.measurement_noise == '0);
  assign stat.out_busy = !out_free;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.estimate = out_est_r;
  assign out_ch.gain     = out_gain_r;

  assign pred_sum = {1'b0, p_r} + {1'b0, cfg.process_noise};
  assign div_ge   = rem_r >= {1'b0, s_r};
  assign div_diff = rem_r - {1'b0, s_r};
  assign div_rem  = div_ge ? div_diff : rem_r;
  assign mul_add  = mplier_r[16] ? {{18{mcand_r[33]}}, mcand_r} : 52'sd0;
  // toward-zero truncation of the product by 2^16
  assign rnd_sum  = acc_r + (acc_r[51] ? 52'sd65535 : 52'sd0);
  assign x_sum    = {{5{x_r[31]}}, x_r} + {acc_r[35], acc_r[35:0]};

  always_comb begin
    p_nxt         = p_r;
    x_nxt         = x_r;
    k_nxt         = k_r;
    s_nxt         = s_r;
    rem_nxt       = rem_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    act_nxt       = act_r;
    meas_nxt      = meas_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_est_nxt   = out_est_r;
    out_gain_nxt  = out_gain_r;
    case (op)
      skf_pkg::OP_WAIT: begin
        if (accept) begin
          act_nxt  = in_ch.action;
          meas_nxt = in_ch.measurement;
        end
      end
      skf_pkg::OP_PRED: begin
        p_nxt = pred_sum[32] ? 32'hFFFF_FFFF : pred_sum[31:0];
      end
      skf_pkg::OP_DIVINIT: begin
        s_nxt   = {1'b0, p_r} + {1'b0, cfg.measurement_noise};
        rem_nxt = {2'b00, p_r};
        k_nxt   = '0;
      end
      skf_pkg::OP_DIVSTEP: begin
        rem_nxt = {div_rem[32:0], 1'b0};
        k_nxt   = {k_r[15:0], div_ge};
      end
      skf_pkg::OP_MULX: begin
        mcand_nxt  = {{2{meas_r[15]}}, meas_r, 16'h0000} - {{2{x_r[31]}}, x_r};
        mplier_nxt = k_r;
        acc_nxt    = '0;
      end
      skf_pkg::OP_MULSTEP: begin
        acc_nxt    = {acc_r[50:0], 1'b0} + mul_add;
        mplier_nxt = {mplier_r[15:0], 1'b0};
      end
      skf_pkg::OP_XROUND: begin
        acc_nxt = rnd_sum >>> 16;
      end
      skf_pkg::OP_XUPD: begin
        if (x_sum[36:31] == 6'b000000 || x_sum[36:31] == 6'b111111) begin
          x_nxt = x_sum[31:0];
        end else if (x_sum[36]) begin
          x_nxt = 32'sh8000_0000;
        end else begin
          x_nxt = 32'sh7FFF_FFFF;
        end
        mcand_nxt  = {2'b00, p_r};
        mplier_nxt = skf_pkg::GAIN_ONE - k_r;
        acc_nxt    = '0;
      end
      skf_pkg::OP_PUPD: begin
        p_nxt = acc_r[47:16];
      end
      skf_pkg::OP_RELOAD: begin
        p_nxt = cfg.initial_error;
        x_nxt = cfg.initial_estimate;
        k_nxt = '0;
      end
      skf_pkg::OP_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_est_nxt   = x_r;
          out_gain_nxt  = k_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r         <= skf_pkg::RST_COVARIANCE;
      x_r         <= skf_pkg::RST_ESTIMATE;
      act_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p_r         <= p_nxt;
      x_r         <= x_nxt;
      act_r       <= act_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    s_r        <= s_nxt;
    rem_r      <= rem_nxt;
    acc_r      <= acc_nxt;
    mcand_r    <= mcand_nxt;
    mplier_r   <= mplier_nxt;
    meas_r     <= meas_nxt;
    out_est_r  <= out_est_nxt;
    out_gain_r <= out_gain_nxt;
  end

endmodule
`default_nettype wire

// ===== design/scalar_kalman_filter_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scalar_kalman_filter_top
// Scalar Kalman filter: estimate and covariance update per sensor sample.
// ----------------------------------------------------------------------------
// sequence: a sample item runs prediction, the 17-step divider and two 17-step
//   multiplier passes (a zero noise sum skips the divider); a reload item loads
//   the reload values. One item is processed at a time: the next is taken only
//   after the result register has room, so items wait while out ready is low
// reset: synchronous active-low rst_n loads the default noise and reload
//   values, covariance one and estimate zero
module scalar_kalman_filter_top (
  input  wire logic   clk,
  input  wire logic   rst_n,
  skf_in_if.sink      in_ch,
  skf_out_if.source   out_ch,
  skf_cfg_if.sink     cfg_ch
);

  skf_pkg::cfg_t     cfg;
  skf_pkg::op_t      op;
  skf_pkg::dp_stat_t stat;

  skf_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  skf_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .op    (op)
  );

  skf_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .op     (op),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .stat   (stat)
  );

endmodule
`default_nettype wire

// ===== sim/scalar_kalman_filter_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_kalman_filter_top_tb
// Self-checking bench for the scalar Kalman filter. A directed table covers
// reload, zero noise sum, unit gain and the range extremes. Random phases then
// change the noise and reload registers between runs of sample and reload
// items. Result items are compared with the table's expected values where a row
// gives them, else with a bit-exact fixed-point predictor, while both handshakes idle at random in most phases.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_top_tb;
  import skf_pkg::*;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_RELOAD = 1'b1;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_TOP = 8'hFF;

  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_ITEMS  = 130;
  localparam int unsigned DIR_ROWS     = 25;

  typedef struct packed {
    logic signed [DATA_W-1:0] estimate;
    logic        [GAIN_W-1:0] gain;
  } kf_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic                     action;
    logic signed [MEAS_W-1:0] meas;
    logic [CFG_IDX_W-1:0]     idx;
    logic [DATA_W-1:0]        wdata;
    logic                     typed;
    kf_result_t               want;
  } dir_row_t;

  localparam dir_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
    '{ROW_ITEM, ACT_RELOAD, 16'sh7FFF, REG_PROCESS_NOISE, 32'h0, 1'b1, '{32'sh0, 17'd0}},
    '{ROW_ITEM, ACT_SAMPLE, 16'sh0000, REG_PROCESS_NOISE, 32'h0, 1'b0, '{32'sh0, 17'd0}},
    '{ROW_ITEM, ACT_SAMPLE, 16'sh7FFF, REG_PROCESS_NOISE, 32'h0, 1'b0, '{32'sh0, 17'd0}},
    '{ROW_ITEM, ACT_SAMPLE, 16'sh8000, REG_PROCESS_NOISE, 32'h0, 1'b0, '{32'sh0, 17'd0}},
    '{ROW_CFG, ACT_SAMPLE, 16'sh0, REG_PROCESS_NOISE, 32'h0, 1'b0, '{32'sh0, 17'd0}},
    '{ROW_CFG, ACT_SAMPLE, 16'sh0, REG_MEASUREMENT_NOISE, 32'h0, 1'b0, '{32'sh0, 17'd0}},
    '{ROW_CFG, ACT_SAMPLE, 16'sh0, REG_INITIAL_ERROR, 32'h0, 1'b0, '{32'sh0, 17'd0}},
    '{ROW_CFG, ACT_SAMPLE, 16'sh0, REG_INITIAL_ESTIMATE, 32'h7FFFFFFF, 1'b0,
      '{32'sh0, 17'd0}},
    '{ROW_ITEM, ACT_RELOAD, 16'sh0000, REG_PROCESS_NOISE, 32'h0, 1'b1,
      '{32'sh7FFFFFFF, 17'd0}},
    // zero noise sum: gain stays 0 and the estimate holds
    '{ROW_ITEM, ACT_SAMPLE, 16'sh1234, REG_PROCESS_NOISE, 32'h0, 1'b1,
      '{32'sh7FFFFFFF, 17'd0}},
    '{ROW_CFG, ACT_SAMPLE, 16'sh0, REG_PROCESS_NOISE, 32'h1, 1'b0, '{32'sh0, 17'd0}},
    // no measurement noise: unit gain, estimate jumps to the sample
    '{ROW_ITEM, ACT_SAMPLE, 16'sh8000, REG_PROCESS_NOISE, 32'h0, 1'b1,
      '{32'sh80000000, 17'h10000}},
    '{ROW_ITEM, ACT_SAMPLE, 16'sh7FFF, REG_PROCESS_NOISE, 32'h0, 1'b1,
      '{32'sh7FFF0000, 17'h10000}},
    '{ROW_ITEM, ACT_SAMPLE, 16'shFFFF, REG_PROCESS_NOISE, 32'h0, 1'b1,
      '{32'shFFFF0000, 17'h10000}},
    '{ROW_CFG, ACT_SAMPLE, 16'sh0, REG_SPARE_LOW, 32'h0, 1'b0, '{32'sh0, 17'd0}},
    '{ROW_CFG, ACT_SAMPLE, 16'sh0, REG_SPARE_TOP, 32'h12345678, 1'b0, '{32'sh0, 17'd0}},
    // writes to unused indexes must leave the reload values alone
    '{ROW_ITEM, ACT_RELOAD, 16'sh5555, REG_PROCESS_NOISE, 32'h0, 1'b1,
      '{32'sh7FFFFFFF, 17'd0}},
    '{ROW_CFG, ACT_SAMPLE, 16'sh0, REG_INITIAL_ESTIMATE, 32'h80000000, 1'b0,
      '{32'sh0, 17'd0}},
    '{ROW_CFG, ACT_SAMPLE, 16'sh0, REG_PROCESS_NOISE, 32'hFFFFFFFF, 1'b0, '{32'sh0, 17'd0}},
    '{ROW_CFG, ACT_SAMPLE, 16'sh0, REG_MEASUREMENT_NOISE, 32'hFFFFFFFF, 1'b0,
      '{32'sh0, 17'd0}},
    '{ROW_CFG, ACT_SAMPLE, 16'sh0, REG_INITIAL_ERROR, 32'hFFFFFFFF, 1'b0, '{32'sh0, 17'd0}},
    '{ROW_ITEM, ACT_RELOAD, 16'shAAAA, REG_PROCESS_NOISE, 32'h0, 1'b1,
      '{32'sh80000000, 17'd0}},
    // covariance saturates at the top of its range
    '{ROW_ITEM, ACT_SAMPLE, 16'sh7FFF, REG_PROCESS_NOISE, 32'h0, 1'b0, '{32'sh0, 17'd0}},
    '{ROW_ITEM, ACT_SAMPLE, 16'sh0000, REG_PROCESS_NOISE, 32'h0, 1'b0, '{32'sh0, 17'd0}},
    '{ROW_ITEM, ACT_SAMPLE, 16'sh8000, REG_PROCESS_NOISE, 32'h0, 1'b0, '{32'sh0, 17'd0}}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  skf_in_if  in_bus ();
  skf_out_if out_bus ();
  skf_cfg_if cfg_bus ();

  scalar_kalman_filter_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  always #10 clk = ~clk;

  // filter state and registers as the block should hold them
  cfg_t                     pred_cfg;
  logic        [DATA_W-1:0] p_cov;
  logic signed [DATA_W-1:0] x_est;

  kf_result_t  pending_results [$];
  int unsigned mismatch_cnt  = 0;
  int unsigned tx_gap_max    = 8;
  int unsigned rx_stall_max  = 8;
  bit          long_hold_req = 1'b0;
  bit          in_live       = 1'b0;
  bit          cfg_live      = 1'b0;

  function automatic kf_result_t kalman_step(input logic act,
                                             input logic signed [MEAS_W-1:0] meas);
    kf_result_t      r;
    longint unsigned p_pred;
    longint unsigned s_sum;
    longint unsigned k;
    longint          d;
    longint          delta;
    longint          x_new;
    k = 0;
    if (act == ACT_RELOAD) begin
      p_cov = pred_cfg.initial_error;
      x_est = pred_cfg.initial_estimate;
    end else begin
      p_pred = 64'(p_cov) + 64'(pred_cfg.process_noise);
      if (p_pred > 64'hFFFF_FFFF) p_pred = 64'hFFFF_FFFF;
      s_sum = p_pred + 64'(pred_cfg.measurement_noise);
      if (s_sum != 0) k = (p_pred << 16) / s_sum;
      d     = longint'(meas) * 65536 - longint'(x_est);
      delta = (longint'(k) * d) / 65536;
      x_new = longint'(x_est) + delta;
      if (x_new > 64'sd2147483647) x_new = 64'sd2147483647;
      else if (x_new < -64'sd2147483648) x_new = -64'sd2147483648;
      x_est = 32'(x_new);
      p_cov = 32'(((64'd65536 - k) * p_pred) >> 16);
    end
    r.estimate = x_est;
    r.gain     = 17'(k);
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pick_noise();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 6))
      0:       v = 32'h0;
      1:       v = 32'hFFFF_FFFF;
      2:       v = 32'($urandom_range(0, 1000));
      3:       v = 32'($urandom_range(0, 32'h0002_0000));
      4:       v = $urandom & 32'h00FF_FFFF;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_item(input logic act, input logic signed [MEAS_W-1:0] meas,
                           input logic typed, input kf_result_t want);
    int unsigned gap;
    kf_result_t  calc;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      if (in_live) begin
        in_bus.valid <= 1'b0;
        in_live = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    if (!in_live) begin
      in_bus.valid <= 1'b1;
      in_live = 1'b1;
    end
    in_bus.action      <= act;
    in_bus.measurement <= meas;
    do @(posedge clk); while (!in_bus.ready);
    calc = kalman_step(act, meas);
    pending_results.push_back(typed ? want : calc);
  endtask

  task automatic stop_input();
    if (in_live) begin
      in_bus.valid <= 1'b0;
      in_live = 1'b0;
    end
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] wdata);
    if (!cfg_live) begin
      cfg_bus.valid <= 1'b1;
      cfg_live = 1'b1;
    end
    cfg_bus.index <= idx;
    cfg_bus.data  <= wdata;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_PROCESS_NOISE:     pred_cfg.process_noise     = wdata;
      REG_MEASUREMENT_NOISE: pred_cfg.measurement_noise = wdata;
      REG_INITIAL_ERROR:     pred_cfg.initial_error     = wdata;
      REG_INITIAL_ESTIMATE:  pred_cfg.initial_estimate  = wdata;
      default: ;
    endcase
  endtask

  task automatic cfg_idle();
    if (cfg_live) begin
      cfg_bus.valid <= 1'b0;
      cfg_live = 1'b0;
    end
  endtask

  // stimulus and final verdict
  initial begin : stimulus
    dir_row_t                 row;
    logic                     act;
    logic signed [MEAS_W-1:0] meas;
    in_bus.valid        = 1'b0;
    in_bus.action       = ACT_SAMPLE;
    in_bus.measurement  = '0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = REG_PROCESS_NOISE;
    cfg_bus.data        = '0;
    out_bus.ready       = 1'b0;
    pred_cfg.process_noise     = RST_PROCESS_NOISE;
    pred_cfg.measurement_noise = RST_MEASUREMENT_NOISE;
    pred_cfg.initial_error     = RST_INITIAL_ERROR;
    pred_cfg.initial_estimate  = RST_INITIAL_ESTIMATE;
    p_cov = RST_COVARIANCE;
    x_est = RST_ESTIMATE;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIR_TABLE[i];
      if (row.kind == ROW_CFG) begin
        stop_input();
        wait_drained();
        write_reg(row.idx, row.wdata);
      end else begin
        cfg_idle();
        send_item(row.action, row.meas, row.typed, row.want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      stop_input();
      wait_drained();
      if (ph == 2) begin
        write_reg(REG_PROCESS_NOISE, 32'h0);
        write_reg(REG_MEASUREMENT_NOISE, 32'h0);
      end else if (ph == 3) begin
        write_reg(REG_PROCESS_NOISE, 32'hFFFF_FFFF);
        write_reg(REG_MEASUREMENT_NOISE, 32'hFFFF_FFFF);
      end else begin
        if ($urandom_range(0, 3) != 0) write_reg(REG_PROCESS_NOISE, pick_noise());
        if ($urandom_range(0, 3) != 0) write_reg(REG_MEASUREMENT_NOISE, pick_noise());
      end
      if ($urandom_range(0, 3) != 0) write_reg(REG_INITIAL_ERROR, pick_noise());
      case ($urandom_range(0, 3))
        0:       write_reg(REG_INITIAL_ESTIMATE, 32'h8000_0000);
        1:       write_reg(REG_INITIAL_ESTIMATE, 32'h7FFF_FFFF);
        default: write_reg(REG_INITIAL_ESTIMATE, $urandom);
      endcase
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LOW, REG_SPARE_TOP)), $urandom);
      cfg_idle();

      tx_gap_max   = (ph <= 1) ? 0 : 8;
      rx_stall_max = (ph == 0) ? 0 : 8;
      // receiver stalls long while the sender keeps offering items
      if (ph == 1) long_hold_req = 1'b1;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 4 && n == PHASE_ITEMS / 2) begin
          stop_input();
          wait_drained();
        end
        act = ($urandom_range(0, 11) == 0) ? ACT_RELOAD : ACT_SAMPLE;
        case ($urandom_range(0, 7))
          0:       meas = 16'sh7FFF;
          1:       meas = 16'sh8000;
          default: meas = 16'($urandom);
        endcase
        send_item(act, meas, 1'b0, '0);
      end
    end

    stop_input();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("scalar_kalman_filter_top_tb: clean");
    end else begin
      $display("scalar_kalman_filter_top_tb: errors");
    end
    $finish;
  end

  // result side: random stalls, compare against the oldest expected item
  initial begin : result_sink
    int unsigned stall;
    kf_result_t  want;
    bit          rx_live;
    rx_live = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        stall = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        stall = $urandom_range(0, rx_stall_max);
      end
      if (stall > 0) begin
        if (rx_live) begin
          out_bus.ready <= 1'b0;
          rx_live = 1'b0;
        end
        repeat (stall) @(posedge clk);
      end
      if (!rx_live) begin
        out_bus.ready <= 1'b1;
        rx_live = 1'b1;
      end
      do @(posedge clk); while (!out_bus.valid);
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: result with nothing pending: estimate %h gain %h",
                   $time, out_bus.estimate, out_bus.gain);
      end else begin
        want = pending_results.pop_front();
        if (out_bus.estimate !== want.estimate || out_bus.gain !== want.gain) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: mismatch: expected estimate %h gain %h, got estimate %h gain %h",
                     $time, want.estimate, want.gain, out_bus.estimate, out_bus.gain);
        end
      end
    end
  end

  // ends the run when no channel moves an item for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("scalar_kalman_filter_top_tb: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/skf_pkg.sv
design/skf_in_if.sv
design/skf_out_if.sv
design/skf_cfg_if.sv
design/skf_cfg_regs.sv
design/skf_seq.sv
design/skf_dp.sv
design/scalar_kalman_filter_top.sv
sim/scalar_kalman_filter_top_tb.sv
